// ----- rtl/hmc_pkg.sv -----
// Shared types and constants for the height map cell update block.
// Holds the request, response and cell word layouts plus opcode codes.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package hmc_pkg;

   // Operation codes carried in the request opcode field
   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_MIN   = 3'd2;
   localparam logic [2:0] OP_MAX   = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // Confidence limits and the max-merge margin of 1.0 in Q16.8
   localparam logic [2:0]        CONF_MAX   = 3'd4;
   localparam logic [2:0]        CONF_ONE   = 3'd1;
   localparam logic signed [24:0] MAX_MARGIN = 25'sd256;

   // Tag layout: low half of block x over low half of block y
   localparam int TAG_W  = 32;
   localparam int HALF_W = 16;
   localparam int CELL_W = 20;

   // Widest slot index for the supported table sizes
   localparam int SLOT_MAX_W = 8;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [19:0] cell_x;
      logic signed [19:0] cell_y;
      logic signed [23:0] height_in;
      logic [2:0]         confidence_in;
   } req_type;

   typedef struct packed {
      logic signed [23:0] height_out;
      logic [2:0]         confidence_out;
      logic               block_hit;
      logic               table_full;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] height;
      logic [2:0]         conf;
   } cell_type;

   typedef struct packed {
      logic     written;
      cell_type value;
   } mem_word_type;

   // Tag table lookup status
   typedef struct packed {
      logic                  hit;
      logic [SLOT_MAX_W-1:0] hit_slot;
      logic                  free_ok;
      logic [SLOT_MAX_W-1:0] free_slot;
   } lookup_type;

   // Tag table update controls
   typedef struct packed {
      logic                  clear_all;
      logic                  alloc;
      logic [SLOT_MAX_W-1:0] slot;
      logic [TAG_W-1:0]      tag;
   } tag_ctl_type;

   // Merge decision for one cell
   typedef struct packed {
      logic     store;
      cell_type value;
   } update_type;

endpackage

// ----- rtl/height_map_cell_update.sv -----
// Top level of the sparse blocked height map: handshakes, sequencer,
// block sweep. Depends on hmc_pkg, hmc_tag_table, hmc_cell_mem, hmc_update.
//
//   port group | direction | payload             | handshake
//   req_*      | in        | hmc_pkg::req_type   | req_valid / req_ready
//   rsp_*      | out       | hmc_pkg::rsp_type   | rsp_valid / rsp_ready
//
// The tag compare and the cell memory read start in the accept cycle; the
// merge and write-back follow in the ST_MOD state. A store that allocates a
// block then sweeps every cell of the new block clean through the single
// write port. Reset frees all blocks at once; cell memory needs no clearing.
// A waiting result holds the merge step until the response register frees.
// BLOCK_SIDE must be a power of two.
`timescale 1ns / 1ps

module height_map_cell_update #(
   parameter int BLOCK_SIDE = 16,
   parameter int NUM_BLOCKS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hmc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hmc_pkg::rsp_type rsp_data
);

   localparam int OFF_W  = $clog2(BLOCK_SIDE);
   localparam int CELL_OFF_W = 2 * OFF_W;
   localparam int DEPTH  = NUM_BLOCKS * BLOCK_SIDE * BLOCK_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_SWEEP
   } state_type;

   state_type                 state_ff, state_in;
   hmc_pkg::req_type          item_ff, item_in;
   hmc_pkg::lookup_type       look_ff, look_in;
   logic [hmc_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic [CELL_OFF_W-1:0]     off_ff, off_in;
   hmc_pkg::cell_type         new_cell_ff, new_cell_in;
   logic [CELL_OFF_W-1:0]     sweep_cnt_ff, sweep_cnt_in;
   hmc_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [hmc_pkg::CELL_W-1:0] blk_x, blk_y;
   logic [hmc_pkg::TAG_W-1:0]         req_tag;
   logic [CELL_OFF_W-1:0]             req_off;
   hmc_pkg::lookup_type               lookup;
   hmc_pkg::tag_ctl_type              tag_ctl;
   logic                              req_accept;
   logic                              rsp_free;

   logic                  rd_en, wr_en;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   hmc_pkg::mem_word_type rd_data, wr_data;

   hmc_pkg::cell_type   old_cell;
   hmc_pkg::update_type upd;
   logic                miss_store;

   // Split cell indices: floor division by shift, offset from low bits
   assign blk_x   = req_data.cell_x >>> OFF_W;
   assign blk_y   = req_data.cell_y >>> OFF_W;
   assign req_tag = {blk_x[hmc_pkg::HALF_W-1:0], blk_y[hmc_pkg::HALF_W-1:0]};
   assign req_off = {req_data.cell_x[OFF_W-1:0], req_data.cell_y[OFF_W-1:0]};

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   hmc_tag_table #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_tag_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_tag (req_tag),
      .ctl        (tag_ctl),
      .lookup     (lookup)
   );

   // Start the cell read in the accept cycle when the block is present
   assign rd_en   = req_accept && lookup.hit;
   assign rd_addr = (ADDR_W'(lookup.hit_slot[SLOT_W-1:0]) << CELL_OFF_W)
                    | ADDR_W'(req_off);

   hmc_cell_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_cell_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Absent block or never-written cell reads as zero
   assign old_cell = (look_ff.hit && rd_data.written) ? rd_data.value : '0;

   hmc_update u_update (
      .opcode        (item_ff.opcode),
      .height_in     (item_ff.height_in),
      .confidence_in (item_ff.confidence_in),
      .old_cell      (old_cell),
      .result        (upd)
   );

   assign miss_store = upd.store && !look_ff.hit;

   // Sequence one transaction: capture, merge and write back, sweep
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      look_in      = look_ff;
      tag_in       = tag_ff;
      off_in       = off_ff;
      new_cell_in  = new_cell_ff;
      sweep_cnt_in = sweep_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tag_ctl      = '0;
      wr_en        = 1'b0;
      wr_addr      = (ADDR_W'(look_ff.hit_slot[SLOT_W-1:0]) << CELL_OFF_W)
                     | ADDR_W'(off_ff);
      wr_data      = '{written: 1'b1, value: upd.value};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in  = req_data;
               look_in  = lookup;
               tag_in   = req_tag;
               off_in   = req_off;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (item_ff.opcode == hmc_pkg::OP_CLEAR) begin
                  rsp_in            = '0;
                  tag_ctl.clear_all = 1'b1;
               end else begin
                  rsp_in.height_out     = old_cell.height;
                  rsp_in.confidence_out = old_cell.conf;
                  rsp_in.block_hit      = look_ff.hit;
                  rsp_in.table_full     = miss_store && !look_ff.free_ok;
                  // Write back into a present block
                  wr_en = upd.store && look_ff.hit;
                  // Allocate the lowest free slot and sweep it
                  if (miss_store && look_ff.free_ok) begin
                     tag_ctl.alloc = 1'b1;
                     tag_ctl.slot  = look_ff.free_slot;
                     tag_ctl.tag   = tag_ff;
                     new_cell_in   = upd.value;
                     sweep_cnt_in  = '0;
                     state_in      = ST_SWEEP;
                  end
               end
            end
         end
         ST_SWEEP: begin
            // Clear every cell of the new block, storing the target cell
            wr_en   = 1'b1;
            wr_addr = (ADDR_W'(look_ff.free_slot[SLOT_W-1:0]) << CELL_OFF_W)
                      | ADDR_W'(sweep_cnt_ff);
            if (sweep_cnt_ff == off_ff) begin
               wr_data = '{written: 1'b1, value: new_cell_ff};
            end else begin
               wr_data = '0;
            end
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, captured transaction and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      look_ff      <= look_in;
      tag_ff       <= tag_in;
      off_ff       <= off_in;
      new_cell_ff  <= new_cell_in;
      sweep_cnt_ff <= sweep_cnt_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted transaction keeps the input closed for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a transaction was in flight");

   // A dropped write never reports a present block
   a_full_excludes_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.table_full && rsp_data.block_hit))
      else $error("table full flagged on a block hit");

   // The cell memory is written only while a transaction is in progress
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !wr_en)
      else $error("cell memory write while idle");

   // A sweep always follows an allocation step
   a_sweep_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_SWEEP) |-> $past(tag_ctl.alloc))
      else $error("block sweep started without an allocation");

endmodule

// ----- rtl/hmc_tag_table.sv -----
// Associative block tag table: valid bits, tags, parallel compare and
// lowest-free-slot search. Depends on hmc_pkg.
`timescale 1ns / 1ps

module hmc_tag_table #(
   parameter int NUM_BLOCKS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [hmc_pkg::TAG_W-1:0] lookup_tag,
   input  hmc_pkg::tag_ctl_type     ctl,
   output hmc_pkg::lookup_type      lookup
);

   localparam int SLOT_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   logic [NUM_BLOCKS-1:0]       valid_ff;
   logic [hmc_pkg::TAG_W-1:0]   tag_ff [NUM_BLOCKS];

   // Compare every entry at once; tags are unique so hits can be OR-ed
   always_comb begin
      lookup = '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         if (valid_ff[i] && (tag_ff[i] == lookup_tag)) begin
            lookup.hit      = 1'b1;
            lookup.hit_slot = lookup.hit_slot | hmc_pkg::SLOT_MAX_W'(i);
         end
      end
      // Scan down so the lowest free slot wins
      for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            lookup.free_ok   = 1'b1;
            lookup.free_slot = hmc_pkg::SLOT_MAX_W'(i);
         end
      end
   end

   // Track allocated slots; clear-all frees every block
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear_all) begin
         valid_ff <= '0;
      end else if (ctl.alloc) begin
         valid_ff[ctl.slot[SLOT_W-1:0]] <= 1'b1;
      end
   end

   // Capture the tag of a newly allocated block
   always_ff @(posedge clock) begin
      if (ctl.alloc) begin
         tag_ff[ctl.slot[SLOT_W-1:0]] <= ctl.tag;
      end
   end

endmodule

// ----- rtl/hmc_cell_mem.sv -----
// Cell storage: one synchronous memory with a write port and a
// registered read port. Depends on hmc_pkg for the word layout.
`timescale 1ns / 1ps

module hmc_cell_mem #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output hmc_pkg::mem_word_type rd_data,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  hmc_pkg::mem_word_type wr_data
);

   hmc_pkg::mem_word_type mem [DEPTH];
   hmc_pkg::mem_word_type rd_data_ff;

   // Write one word per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/hmc_update.sv -----
// Merge rules for one cell: plain write, OP_MIN and OP_MAX height merges.
// Pure logic on the old cell and the request. Depends on hmc_pkg.
`timescale 1ns / 1ps

module hmc_update (
   input  logic [2:0]          opcode,
   input  logic signed [23:0]  height_in,
   input  logic [2:0]          confidence_in,
   input  hmc_pkg::cell_type   old_cell,
   output hmc_pkg::update_type result
);

   logic signed [24:0] old_plus_margin;
   logic signed [24:0] height_ext;

   assign old_plus_margin = $signed({old_cell.height[23], old_cell.height})
                            + hmc_pkg::MAX_MARGIN;
   assign height_ext      = $signed({height_in[23], height_in});

   // Pick the stored value for the operation
   always_comb begin
      result = '0;
      case (opcode)
         hmc_pkg::OP_WRITE: begin
            result.store        = 1'b1;
            result.value.height = height_in;
            result.value.conf   = confidence_in;
         end
         hmc_pkg::OP_MIN: begin
            result.store = 1'b1;
            if (old_cell.conf == 3'd0) begin
               result.value.height = height_in;
               result.value.conf   = hmc_pkg::CONF_ONE;
            end else begin
               result.value.height = (height_in > old_cell.height) ? height_in
                                                                   : old_cell.height;
               result.value.conf   = (old_cell.conf >= hmc_pkg::CONF_MAX)
                                     ? hmc_pkg::CONF_MAX : old_cell.conf + 3'd1;
            end
         end
         hmc_pkg::OP_MAX: begin
            // Update only a known cell that is not far below the new height
            if ((old_cell.conf != 3'd0) && (old_plus_margin > height_ext)) begin
               result.store = 1'b1;
               if (old_cell.conf < hmc_pkg::CONF_MAX) begin
                  result.value.height = height_in;
                  result.value.conf   = hmc_pkg::CONF_MAX;
               end else begin
                  // conf is at least four here, so one less stays above one
                  result.value.height = old_cell.height;
                  result.value.conf   = old_cell.conf - 3'd1;
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ----- dv/height_map_checker.sv -----
// Response checker for the height map cell update block.
// Watches both channels, predicts every response and compares it field by field.
// Depends on hmc_pkg for the request, response and cell layouts.
`timescale 1ns / 1ps

module height_map_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  hmc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  hmc_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count,
   output int               responses_checked,
   output int               hit_count,
   output int               full_count
);

   localparam int SIDE_BITS  = 4;
   localparam int SIDE       = 1 << SIDE_BITS;
   localparam int SLOTS      = 16;
   localparam int BLOCK_CELLS = SIDE * SIDE;
   localparam int CELLS      = SLOTS * BLOCK_CELLS;

   // Shadow copy of the tag table and the cell store
   logic [hmc_pkg::TAG_W-1:0] slot_tag  [SLOTS];
   logic                      slot_used [SLOTS];
   logic                      cell_set  [CELLS];
   hmc_pkg::cell_type         cell_mem  [CELLS];

   hmc_pkg::rsp_type predicted_rsp_q[$];
   int      errors;
   int      checked;
   int      hits;
   int      fulls;

   // Apply one request to the shadow map and return the response it should give
   function automatic hmc_pkg::rsp_type apply_cell_op(hmc_pkg::req_type r);
      hmc_pkg::rsp_type          res;
      logic [hmc_pkg::TAG_W-1:0] tag;
      logic [2*SIDE_BITS-1:0]    offs;
      int                        slot;
      int                        index;
      bit                        hit;
      bit                        store;
      bit                        full;
      logic signed [23:0]        old_h;
      logic signed [23:0]        new_h;
      logic [2:0]                old_c;
      logic [2:0]                new_c;
      logic signed [24:0]        old_plus_margin;
      logic signed [24:0]        wide_in;
      res   = '0;
      store = 1'b0;
      full  = 1'b0;
      old_h = '0;
      old_c = '0;
      new_h = '0;
      new_c = '0;
      index = 0;

      // Clear all frees every block and reports zeros
      if (r.opcode == hmc_pkg::OP_CLEAR) begin
         for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
         return res;
      end

      // Floor division by the block side is the upper bits of each index
      tag  = {r.cell_x[hmc_pkg::CELL_W-1:SIDE_BITS], r.cell_y[hmc_pkg::CELL_W-1:SIDE_BITS]};
      offs = {r.cell_x[SIDE_BITS-1:0], r.cell_y[SIDE_BITS-1:0]};

      slot = -1;
      for (int i = 0; i < SLOTS; i++)
         if (slot < 0 && slot_used[i] && slot_tag[i] == tag) slot = i;
      hit = (slot >= 0);
      if (hit) begin
         index = slot * BLOCK_CELLS + int'(offs);
         if (cell_set[index]) begin
            old_h = cell_mem[index].height;
            old_c = cell_mem[index].conf;
         end
      end

      // Decide the new cell contents
      case (r.opcode)
         hmc_pkg::OP_WRITE: begin
            store = 1'b1;
            new_h = r.height_in;
            new_c = r.confidence_in;
         end
         hmc_pkg::OP_MIN: begin
            store = 1'b1;
            if (old_c == 3'd0) begin
               new_h = r.height_in;
               new_c = hmc_pkg::CONF_ONE;
            end else begin
               new_h = (r.height_in > old_h) ? r.height_in : old_h;
               new_c = (old_c >= hmc_pkg::CONF_MAX) ? hmc_pkg::CONF_MAX
                                                    : old_c + hmc_pkg::CONF_ONE;
            end
         end
         hmc_pkg::OP_MAX: begin
            old_plus_margin = {old_h[23], old_h};
            old_plus_margin = old_plus_margin + hmc_pkg::MAX_MARGIN;
            wide_in         = {r.height_in[23], r.height_in};
            if (old_c != 3'd0 && old_plus_margin > wide_in) begin
               store = 1'b1;
               if (old_c < hmc_pkg::CONF_MAX) begin
                  new_h = r.height_in;
                  new_c = hmc_pkg::CONF_MAX;
               end else begin
                  new_h = old_h;
                  new_c = old_c - hmc_pkg::CONF_ONE;
               end
            end
         end
         default: ;
      endcase

      // Allocate the lowest free slot on a store to an absent block
      if (store) begin
         if (!hit) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot < 0 && !slot_used[i]) begin
                  slot         = i;
                  slot_used[i] = 1'b1;
                  slot_tag[i]  = tag;
                  for (int c = 0; c < BLOCK_CELLS; c++) cell_set[i * BLOCK_CELLS + c] = 1'b0;
               end
            end
            if (slot < 0) full = 1'b1;
            else index = slot * BLOCK_CELLS + int'(offs);
         end
         if (!full) begin
            cell_mem[index].height = new_h;
            cell_mem[index].conf   = new_c;
            cell_set[index]        = 1'b1;
         end
      end

      res.height_out     = old_h;
      res.confidence_out = old_c;
      res.block_hit      = hit;
      res.table_full     = full;
      return res;
   endfunction

   // Report one field that differs from the prediction
   task automatic check_field(string name, logic [23:0] want_v, logic [23:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   // Retire responses first, then record the prediction for a new transaction
   always @(posedge clock) begin : watch_channels
      hmc_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
         for (int i = 0; i < CELLS; i++) cell_set[i] = 1'b0;
         predicted_rsp_q.delete();
         errors  = 0;
         checked = 0;
         hits    = 0;
         fulls   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %p", $time, rsp_data);
               errors++;
            end else begin
               want = predicted_rsp_q.pop_front();
               check_field("height_out", want.height_out, rsp_data.height_out);
               check_field("confidence_out", want.confidence_out, rsp_data.confidence_out);
               check_field("block_hit", want.block_hit, rsp_data.block_hit);
               check_field("table_full", want.table_full, rsp_data.table_full);
               hits  += want.block_hit;
               fulls += want.table_full;
            end
            checked++;
         end
         if (req_valid && req_ready) predicted_rsp_q.push_back(apply_cell_op(req_data));
      end
      error_count       <= errors;
      pending_count     <= predicted_rsp_q.size();
      responses_checked <= checked;
      hit_count         <= hits;
      full_count        <= fulls;
   end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the height map cell update block: clock, reset, stimulus, verdict.
// Depends on hmc_pkg, height_map_cell_update and height_map_checker.
`timescale 1ns / 1ps

module tb;

   localparam int TOTAL_ITEMS    = 1550;
   localparam int PAUSE_AT       = 800;
   localparam int HOLD_AT        = 300;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int POOL           = 24;

   // Opcodes outside the defined set, handled as reads
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   hmc_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   hmc_pkg::rsp_type rsp_data;

   int error_count;
   int pending_count;
   int responses_checked;
   int hit_count;
   int full_count;
   int sent_count;
   int idle_cycles;

   logic [15:0] blk_x_pool [POOL];
   logic [15:0] blk_y_pool [POOL];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   height_map_cell_update #(
      .BLOCK_SIDE(16),
      .NUM_BLOCKS(16)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   height_map_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .responses_checked(responses_checked),
      .hit_count        (hit_count),
      .full_count       (full_count)
   );

   function automatic hmc_pkg::req_type cell_req(logic [2:0] op, logic signed [19:0] x,
                                                 logic signed [19:0] y,
                                                 logic signed [23:0] h, logic [2:0] c);
      hmc_pkg::req_type r;
      r.opcode        = op;
      r.cell_x        = x;
      r.cell_y        = y;
      r.height_in     = h;
      r.confidence_in = c;
      return r;
   endfunction

   // Mostly small heights so merges compare near each other, plus wide and extreme ones
   function automatic logic [23:0] pick_height();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         v = int'($urandom_range(0, 2047)) - 1024;
         return v[23:0];
      end
      if (r < 75) return 24'($urandom);
      case ($urandom_range(0, 3))
         0:       return 24'h7fffff;
         1:       return 24'h800000;
         2:       return 24'h000000;
         default: return 24'hffffff;
      endcase
   endfunction

   function automatic logic [2:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return hmc_pkg::OP_READ;
      if (r < 40) return hmc_pkg::OP_WRITE;
      if (r < 70) return hmc_pkg::OP_MIN;
      return hmc_pkg::OP_MAX;
   endfunction

   // Offer one transaction after a random gap, hold it until accepted
   task automatic offer(input hmc_pkg::req_type item);
      int gap;
      gap = (sent_count % 250 < 50) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Stop offering and wait until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Receiver: random stall per response, one long hold-off mid-run
   initial begin : receiver
      int stall;
      int taken;
      taken     = 0;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = (taken % 200 < 40) ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int          pick;
      int          burst;
      int          k;
      logic [3:0]  ox;
      logic [3:0]  oy;
      logic [19:0] cx;
      logic [19:0] cy;
      logic [2:0]  conf;
      sent_count = 0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;

      // Block pool: two corner blocks and the two blocks at the origin first, the rest random
      blk_x_pool[0] = 16'h8000; blk_y_pool[0] = 16'h7fff;
      blk_x_pool[1] = 16'h7fff; blk_y_pool[1] = 16'h8000;
      blk_x_pool[2] = 16'h0000; blk_y_pool[2] = 16'h0000;
      blk_x_pool[3] = 16'hffff; blk_y_pool[3] = 16'hffff;
      for (int i = 4; i < POOL; i++) begin
         blk_x_pool[i] = 16'($urandom);
         blk_y_pool[i] = 16'($urandom);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, merge chains to saturation, extremes, spare opcodes, clear
      offer(cell_req(hmc_pkg::OP_READ,  20'sd0, 20'sd0, 24'sd77, 3'd2));
      offer(cell_req(hmc_pkg::OP_MAX,   20'sd0, 20'sd0, -24'sd5, 3'd0));
      offer(cell_req(hmc_pkg::OP_MIN,   20'sd0, 20'sd0, 24'sd100, 3'd0));
      offer(cell_req(hmc_pkg::OP_MIN,   20'sd0, 20'sd0, -24'sd500, 3'd0));
      offer(cell_req(hmc_pkg::OP_MIN,   20'sd0, 20'sd0, 24'sd2000, 3'd0));
      offer(cell_req(hmc_pkg::OP_MIN,   20'sd0, 20'sd0, 24'sd50, 3'd0));
      offer(cell_req(hmc_pkg::OP_MAX,   20'sd0, 20'sd0, 24'sd2255, 3'd0));
      offer(cell_req(hmc_pkg::OP_MAX,   20'sd0, 20'sd0, 24'sd2256, 3'd0));
      offer(cell_req(hmc_pkg::OP_MAX,   20'sd0, 20'sd0, -24'sd8388608, 3'd0));
      offer(cell_req(hmc_pkg::OP_WRITE, 20'sd0, 20'sd0, 24'sd8388607, 3'd7));
      offer(cell_req(hmc_pkg::OP_MIN,   20'sd0, 20'sd0, 24'sd0, 3'd0));
      offer(cell_req(hmc_pkg::OP_READ,  20'sd0, 20'sd0, 24'sd0, 3'd0));
      offer(cell_req(hmc_pkg::OP_WRITE, -20'sd1, -20'sd1, -24'sd8388608, 3'd0));
      offer(cell_req(hmc_pkg::OP_READ,  -20'sd1, -20'sd1, 24'sd0, 3'd0));
      offer(cell_req(hmc_pkg::OP_MIN,   -20'sd1, -20'sd1, 24'sd0, 3'd0));
      offer(cell_req(hmc_pkg::OP_WRITE, 20'sd524287, -20'sd524288, -24'sd1, 3'd4));
      offer(cell_req(hmc_pkg::OP_READ,  20'sd524287, -20'sd524288, 24'sd0, 3'd0));
      offer(cell_req(hmc_pkg::OP_READ,  -20'sd524288, 20'sd524287, 24'sd0, 3'd0));
      offer(cell_req(OP_SPARE_A, 20'sd0, 20'sd0, 24'sd9, 3'd1));
      offer(cell_req(OP_SPARE_B, -20'sd1, -20'sd1, 24'sd9, 3'd1));
      offer(cell_req(OP_SPARE_C, 20'sd524287, -20'sd524288, 24'sd9, 3'd1));
      offer(cell_req(hmc_pkg::OP_CLEAR, 20'sd123, -20'sd45, -24'sd1, 3'd7));
      offer(cell_req(hmc_pkg::OP_READ,  20'sd0, 20'sd0, 24'sd0, 3'd0));
      offer(cell_req(hmc_pkg::OP_MAX,   -20'sd1, -20'sd1, -24'sd8388608, 3'd0));
      drain_responses();

      // Random: bursts on one cell of a pooled block, with noise and occasional clears
      while (sent_count < TOTAL_ITEMS) begin
         if (sent_count >= PAUSE_AT && sent_count < PAUSE_AT + 6) drain_responses();
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            offer(cell_req(hmc_pkg::OP_CLEAR, 20'($urandom), 20'($urandom), 24'($urandom),
                           3'($urandom)));
         end else if (pick < 14) begin
            offer(cell_req(3'($urandom_range(0, 7)), 20'($urandom), 20'($urandom),
                           pick_height(), 3'($urandom)));
         end else begin
            k  = $urandom_range(0, POOL - 1);
            ox = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3)) : 4'($urandom);
            oy = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3)) : 4'($urandom);
            cx = {blk_x_pool[k], ox};
            cy = {blk_y_pool[k], oy};
            burst = $urandom_range(1, 6);
            repeat (burst) begin
               conf = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 4)) : 3'($urandom);
               offer(cell_req(pick_op(), cx, cy, pick_height(), conf));
            end
         end
      end

      // Wait for the last responses, then let any block sweep finish
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses: %0d block hits, %0d table-full drops.",
               sent_count, responses_checked, hit_count, full_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
